### sv/abff_pkg.sv
package abff_pkg;

   localparam int MAX_BITS_DEFAULT = 256;
   localparam int BITS_PER_BYTE = 8;
   localparam int BIT_COUNT_W = 9;
   localparam int KIND_W = 2;
   localparam int INDEX_W = 8;
   localparam int STATUS_W = 2;
   localparam int FOUND_W = 8;

   localparam logic [BIT_COUNT_W-1:0] BIT_COUNT_RESET = 9'd256;
   localparam logic [BITS_PER_BYTE-1:0] FULL_BYTE = 8'hFF;

   typedef enum logic [KIND_W-1:0] {
      KIND_SET,
      KIND_CLEAR,
      KIND_TEST,
      KIND_FIND
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_RANGE,
      STATUS_FULL
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS,
      ST_FIND,
      ST_DONE
   } state_type;

   function automatic logic [2:0] first_zero(input logic [BITS_PER_BYTE-1:0] value);
      logic [2:0] pos;
      pos = 3'd0;
      for (int i = BITS_PER_BYTE - 1; i >= 0; i--) begin
         if (!value[i]) begin
            pos = 3'(i);
         end
      end
      return pos;
   endfunction

endpackage

### sv/abff_ram.sv
module abff_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/abff_ctrl.sv
module abff_ctrl #(
   parameter int MAX_BITS = abff_pkg::MAX_BITS_DEFAULT,
   localparam int STORE_BYTES = (MAX_BITS + 7) / 8,
   localparam int ADDR_W = STORE_BYTES > 1 ? $clog2(STORE_BYTES) : 1,
   localparam int LEN_W = $clog2(MAX_BITS + 1),
   localparam int CNT_W = $clog2(STORE_BYTES + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [LEN_W-1:0]                 len,
   input  logic [CNT_W-1:0]                 nbytes,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [abff_pkg::KIND_W-1:0]      req_kind,
   input  logic [abff_pkg::INDEX_W-1:0]     req_index,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [abff_pkg::STATUS_W-1:0]    rsp_status,
   output logic                             rsp_bit_value,
   output logic [abff_pkg::FOUND_W-1:0]     rsp_found_index
);

   import abff_pkg::*;

   localparam int IW = LEN_W > INDEX_W ? LEN_W : INDEX_W;
   localparam int RES_W = ADDR_W + 3;
   localparam int CW = RES_W > LEN_W ? RES_W : LEN_W;

   state_type              state_ff, state_in;
   kind_type               kind_ff, kind_in;
   logic [2:0]             bitsel_ff, bitsel_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   status_type             res_status_ff, res_status_in;
   logic                   res_bit_ff, res_bit_in;
   logic [FOUND_W-1:0]     res_found_ff, res_found_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic                   rsp_bit_ff;
   logic [FOUND_W-1:0]     rsp_found_ff;

   logic                   accept;
   logic                   out_free;
   logic                   mem_wr_en;
   logic [ADDR_W-1:0]      mem_wr_addr;
   logic [7:0]             mem_wr_data;
   logic                   mem_rd_en;
   logic [ADDR_W-1:0]      mem_rd_addr;
   logic [7:0]             mem_rd_data;
   logic [7:0]             bit_mask;
   logic [RES_W-1:0]       find_pos;
   logic                   last_byte;
   logic                   clear_last;

   abff_ram #(
      .WIDTH(BITS_PER_BYTE),
      .DEPTH(STORE_BYTES)
   ) u_store (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign bit_mask = 8'(1) << bitsel_ff;
   assign find_pos = {addr_ff, first_zero(mem_rd_data)};
   assign last_byte = (CNT_W'(addr_ff) + CNT_W'(1)) == nbytes;
   assign clear_last = CNT_W'(addr_ff) == CNT_W'(STORE_BYTES - 1);

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      bitsel_in = bitsel_ff;
      addr_in = addr_ff;
      res_status_in = res_status_ff;
      res_bit_in = res_bit_ff;
      res_found_in = res_found_ff;
      mem_wr_en = 1'b0;
      mem_wr_addr = addr_ff;
      mem_wr_data = '0;
      mem_rd_en = 1'b0;
      mem_rd_addr = addr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en = 1'b1;
            addr_in = addr_ff + ADDR_W'(1);
            if (clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               kind_in = kind_type'(req_kind);
               bitsel_in = req_index[2:0];
               res_status_in = STATUS_OK;
               res_bit_in = 1'b0;
               res_found_in = '0;
               if (kind_type'(req_kind) == KIND_FIND) begin
                  if (nbytes == '0) begin
                     res_status_in = STATUS_FULL;
                     state_in = ST_DONE;
                  end else begin
                     mem_rd_en = 1'b1;
                     mem_rd_addr = '0;
                     addr_in = '0;
                     state_in = ST_FIND;
                  end
               end else if (IW'(req_index) >= IW'(len)) begin
                  res_status_in = STATUS_RANGE;
                  state_in = ST_DONE;
               end else begin
                  mem_rd_en = 1'b1;
                  mem_rd_addr = ADDR_W'(req_index[INDEX_W-1:3]);
                  addr_in = ADDR_W'(req_index[INDEX_W-1:3]);
                  state_in = ST_ACCESS;
               end
            end
         end
         ST_ACCESS: begin
            case (kind_ff)
               KIND_SET: begin
                  mem_wr_en = 1'b1;
                  mem_wr_data = mem_rd_data | bit_mask;
               end
               KIND_CLEAR: begin
                  mem_wr_en = 1'b1;
                  mem_wr_data = mem_rd_data & ~bit_mask;
               end
               default: begin
                  res_bit_in = |(mem_rd_data & bit_mask);
               end
            endcase
            state_in = ST_DONE;
         end
         ST_FIND: begin
            if (mem_rd_data != FULL_BYTE) begin
               if (CW'(find_pos) < CW'(len)) begin
                  res_found_in = FOUND_W'(find_pos);
               end else begin
                  res_status_in = STATUS_FULL;
               end
               state_in = ST_DONE;
            end else if (last_byte) begin
               res_status_in = STATUS_FULL;
               state_in = ST_DONE;
            end else begin
               mem_rd_en = 1'b1;
               mem_rd_addr = addr_ff + ADDR_W'(1);
               addr_in = addr_ff + ADDR_W'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = (rsp_valid_ff && rsp_stall) || (state_ff == ST_DONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      bitsel_ff <= bitsel_in;
      res_status_ff <= res_status_in;
      res_bit_ff <= res_bit_in;
      res_found_ff <= res_found_in;
      if (state_ff == ST_DONE && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_bit_ff <= res_bit_ff;
         rsp_found_ff <= res_found_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_bit_value = rsp_bit_ff;
   assign rsp_found_index = rsp_found_ff;

   a_write_only_when_owned: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == ST_CLEAR) ||
         (state_ff == ST_ACCESS && (kind_ff == KIND_SET || kind_ff == KIND_CLEAR)))
      else $error("store written outside clear pass or set/clear update");

   a_scan_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIND) |-> (CNT_W'(addr_ff) < nbytes))
      else $error("find scan beyond active bytes");

   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("finished request not moved to the output register");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STATUS_OK) |-> (!rsp_bit_ff && rsp_found_ff == '0))
      else $error("error response carries nonzero data fields");

endmodule

### sv/allocation_bitmap_find_first_free.sv
// Channel   Direction  Handshake                 Payload
// req_      in         req_valid / req_stall     req_kind, req_index
// rsp_      out        rsp_valid / rsp_stall     rsp_status, rsp_bit_value, rsp_found_index
// csr_      in         csr_we                    csr_wdata (bit count)
//
// Set, clear and test pass through the access state and the done state before a valid
// response; an out-of-range index or an empty bitmap goes straight to the done state.
// Find reads one byte of the store per cycle through the single read port. After reset
// the store is cleared one byte per cycle, all MAX_BITS/8 bytes rounded up,
// while req_stall stays high. A stalled response waits in its output register; the next
// request is taken meanwhile and holds in the done state until the register frees.
module allocation_bitmap_find_first_free #(
   parameter int MAX_BITS = abff_pkg::MAX_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [abff_pkg::KIND_W-1:0]           req_kind,
   input  logic [abff_pkg::INDEX_W-1:0]          req_index,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [abff_pkg::STATUS_W-1:0]         rsp_status,
   output logic                                  rsp_bit_value,
   output logic [abff_pkg::FOUND_W-1:0]          rsp_found_index,
   input  logic                                  csr_we,
   input  logic [abff_pkg::BIT_COUNT_W-1:0]      csr_wdata
);

   import abff_pkg::*;

   localparam int STORE_BYTES = (MAX_BITS + 7) / 8;
   localparam int LEN_W = $clog2(MAX_BITS + 1);
   localparam int CNT_W = $clog2(STORE_BYTES + 1);
   localparam int CMP_W = LEN_W > BIT_COUNT_W ? LEN_W : BIT_COUNT_W;

   logic [BIT_COUNT_W-1:0]  bit_count_ff, bit_count_in;
   logic [CMP_W-1:0]        len_wide;
   logic [LEN_W-1:0]        len;
   logic [LEN_W:0]          len_round;
   logic [CNT_W-1:0]        nbytes;

   assign bit_count_in = csr_we ? csr_wdata : bit_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff <= BIT_COUNT_RESET;
      end else begin
         bit_count_ff <= bit_count_in;
      end
   end

   // Counts above the store size saturate at the store size.
   assign len_wide = (CMP_W'(bit_count_ff) > CMP_W'(MAX_BITS)) ? CMP_W'(MAX_BITS)
                                                               : CMP_W'(bit_count_ff);
   assign len = LEN_W'(len_wide);
   assign len_round = (LEN_W + 1)'(len) + (LEN_W + 1)'(BITS_PER_BYTE - 1);
   assign nbytes = CNT_W'(len_round >> 3);

   abff_ctrl #(
      .MAX_BITS(MAX_BITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .len            (len),
      .nbytes         (nbytes),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_index      (req_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_bit_value  (rsp_bit_value),
      .rsp_found_index(rsp_found_index)
   );

endmodule

### bench/tb_top.sv
module tb_top;
   import abff_pkg::*;

   localparam int STORE_BYTES = MAX_BITS_DEFAULT / BITS_PER_BYTE;
   localparam int IDLE_LIMIT = 2000;

   typedef struct packed {
      kind_type kind;
      logic [INDEX_W-1:0] index;
   } request_type;

   typedef struct packed {
      status_type status;
      logic bit_value;
      logic [FOUND_W-1:0] found_index;
   } result_type;

   typedef enum {FLOW_FREE, FLOW_COIN, FLOW_SPARSE, FLOW_PERIODIC} flow_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [KIND_W-1:0] req_kind = '0;
   logic [INDEX_W-1:0] req_index = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic rsp_bit_value;
   logic [FOUND_W-1:0] rsp_found_index;
   logic csr_we = 1'b0;
   logic [BIT_COUNT_W-1:0] csr_wdata = '0;

   logic [BITS_PER_BYTE-1:0] slot_bytes [STORE_BYTES];
   logic [BIT_COUNT_W-1:0] bit_count_shadow;
   request_type pending_requests [$];
   result_type awaited_results [$];
   int phase_bits [$] = '{1, 8, 9, 2, 17, 256, 300, 20, 64, 255, 0, 7, 511};
   int unsigned issued_count = 0;
   int unsigned answered_count = 0;
   int unsigned error_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned stall_phase = 0;
   int fill_mark = 0;
   flow_mode_type flow_mode = FLOW_FREE;

   allocation_bitmap_find_first_free #(
      .MAX_BITS(MAX_BITS_DEFAULT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_index(req_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_bit_value(rsp_bit_value),
      .rsp_found_index(rsp_found_index),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int active_bits();
      return (bit_count_shadow > MAX_BITS_DEFAULT) ? MAX_BITS_DEFAULT : int'(bit_count_shadow);
   endfunction

   function automatic result_type apply_bitmap_request(request_type r);
      result_type res;
      int len;
      int byte_sel;
      int pos;
      int nbytes;
      logic searching;
      logic [BITS_PER_BYTE-1:0] mask;
      res = '{STATUS_OK, 1'b0, '0};
      len = active_bits();
      if (r.kind != KIND_FIND) begin
         if (int'(r.index) >= len) begin
            res.status = STATUS_RANGE;
         end else begin
            byte_sel = r.index / BITS_PER_BYTE;
            mask = BITS_PER_BYTE'(1) << (r.index % BITS_PER_BYTE);
            case (r.kind)
               KIND_SET: begin
                  slot_bytes[byte_sel] = slot_bytes[byte_sel] | mask;
               end
               KIND_CLEAR: begin
                  slot_bytes[byte_sel] = slot_bytes[byte_sel] & ~mask;
               end
               default: begin
                  res.bit_value = |(slot_bytes[byte_sel] & mask);
               end
            endcase
         end
      end else begin
         res.status = STATUS_FULL;
         nbytes = (len + BITS_PER_BYTE - 1) / BITS_PER_BYTE;
         searching = 1'b1;
         for (int i = 0; i < nbytes && searching; i++) begin
            if (slot_bytes[i] != FULL_BYTE) begin
               searching = 1'b0;
               pos = 0;
               while (pos < BITS_PER_BYTE && slot_bytes[i][pos]) begin
                  pos++;
               end
               if (i * BITS_PER_BYTE + pos < len) begin
                  res.status = STATUS_OK;
                  res.found_index = FOUND_W'(i * BITS_PER_BYTE + pos);
               end
            end
         end
      end
      return res;
   endfunction

   task automatic push_request(kind_type k, int idx);
      pending_requests.push_back(request_type'{k, INDEX_W'(idx)});
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || issued_count != answered_count) begin
         @(posedge clock);
      end
   endtask

   task automatic write_bit_count(int value);
      wait_drained();
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= BIT_COUNT_W'(value);
      bit_count_shadow = BIT_COUNT_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Most sets advance a fill mark so that the bitmap fills from the bottom and finds
   // have to skip full bytes; a few clears punch holes below the mark.
   task automatic random_phase(int value, int count);
      int len;
      int pick;
      write_bit_count(value);
      len = active_bits();
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (len == 0 || pick >= 85) begin
            push_request(kind_type'($urandom_range(0, 3)), $urandom_range(0, 255));
         end else if (pick < 40) begin
            fill_mark = fill_mark % len;
            push_request(KIND_SET, fill_mark);
            fill_mark++;
         end else if (pick < 47) begin
            push_request(KIND_SET, $urandom_range(0, len - 1));
         end else if (pick < 53) begin
            push_request(KIND_CLEAR, $urandom_range(0, fill_mark % len));
         end else if (pick < 68) begin
            push_request(KIND_TEST, $urandom_range(0, len - 1));
         end else begin
            push_request(KIND_FIND, $urandom_range(0, 255));
         end
      end
   endtask

   initial begin
      for (int i = 0; i < STORE_BYTES; i++) begin
         slot_bytes[i] = '0;
      end
      bit_count_shadow = BIT_COUNT_RESET;

      push_request(KIND_FIND, 0);
      push_request(KIND_SET, 0);
      push_request(KIND_SET, 255);
      push_request(KIND_TEST, 0);
      push_request(KIND_TEST, 255);
      push_request(KIND_TEST, 128);
      push_request(KIND_FIND, 255);
      push_request(KIND_CLEAR, 0);
      push_request(KIND_FIND, 0);
      push_request(KIND_CLEAR, 255);
      push_request(KIND_TEST, 255);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // With three bits in use a full first byte tail must still report full.
      write_bit_count(3);
      push_request(KIND_SET, 0);
      push_request(KIND_SET, 1);
      push_request(KIND_SET, 2);
      push_request(KIND_FIND, 0);
      push_request(KIND_TEST, 3);
      push_request(KIND_CLEAR, 1);
      push_request(KIND_FIND, 0);
      push_request(KIND_SET, 1);

      write_bit_count(0);
      push_request(KIND_SET, 0);
      push_request(KIND_CLEAR, 7);
      push_request(KIND_TEST, 0);
      push_request(KIND_FIND, 0);

      // A count above the store size saturates, and bits written earlier stay set.
      write_bit_count(511);
      push_request(KIND_TEST, 2);
      push_request(KIND_FIND, 0);
      push_request(KIND_TEST, 255);

      foreach (phase_bits[i]) begin
         random_phase(phase_bits[i], (phase_bits[i] == 256) ? 60 : 25);
      end
      random_phase($urandom_range(1, 256), 25);
      random_phase($urandom_range(0, 511), 25);

      wait_drained();
      repeat (40) @(posedge clock);
      if (error_count == 0 && awaited_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   always @(posedge clock) begin : request_driver
      request_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            awaited_results.push_back(
               apply_bitmap_request(request_type'{kind_type'(req_kind), req_index}));
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            next_req = pending_requests.pop_front();
            issued_count++;
            req_valid <= 1'b1;
            req_kind <= next_req.kind;
            req_index <= next_req.index;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         flow_mode = flow_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(4, 60);
      end
      stall_left--;
      stall_phase++;
      case (flow_mode)
         FLOW_FREE: begin
            rsp_stall <= 1'b0;
         end
         FLOW_COIN: begin
            rsp_stall <= 1'($urandom_range(0, 1));
         end
         FLOW_SPARSE: begin
            rsp_stall <= ($urandom_range(0, 7) == 0);
         end
         default: begin
            rsp_stall <= stall_phase[2];
         end
      endcase
   end

   always @(posedge clock) begin : result_monitor
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         answered_count++;
         if (awaited_results.size() == 0) begin
            $error("response with no request waiting: status %0d", rsp_status);
            error_count++;
         end else begin
            want = awaited_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_bit_value !== want.bit_value) begin
               $error("bit_value: expected %0d, actual %0d", want.bit_value, rsp_bit_value);
               error_count++;
            end
            if (rsp_found_index !== want.found_index) begin
               $error("found_index: expected %0d, actual %0d", want.found_index,
                      rsp_found_index);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
